// ===== rtl/fcis_pkg.sv =====
// ----------------------------------------------------------------------------
// fcis_pkg
// Types and constants shared by the id set front end, queue and engine.
// ----------------------------------------------------------------------------
package fcis_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_DELETE,
    OP_QUERY,
    OP_BAD,
    OP_RESERVED
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DECIDE,
    BK_MOVE
  } back_state_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id_value;
  } set_in_t;

  typedef struct packed {
    logic               status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } set_out_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] id_value;
  } work_t;

endpackage

// ===== rtl/fcis_front.sv =====
// ----------------------------------------------------------------------------
// fcis_front
// Holds the reserved id register and classifies each accepted command.
// ----------------------------------------------------------------------------
module fcis_front import fcis_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  set_in_t           item,
  input  logic              q_full,
  output logic              busy,
  output logic              push,
  output work_t             push_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ID_W-1:0]   cfg_data
);

  logic [ID_W-1:0] reserved_id;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign push      = start && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_id <= '1;
    end else if (cfg_valid && cfg_ready) begin
      reserved_id <= cfg_data;
    end
  end

  always_comb begin
    push_data.id_value = item.id_value;
    if (item.id_value == reserved_id) begin
      push_data.op = OP_RESERVED;
    end else begin
      case (cmd_t'(item.cmd))
        CMD_ADD:    push_data.op = OP_ADD;
        CMD_DELETE: push_data.op = OP_DELETE;
        CMD_QUERY:  push_data.op = OP_QUERY;
        default:    push_data.op = OP_BAD;
      endcase
    end
  end

endmodule

// ===== rtl/fcis_queue.sv =====
// ----------------------------------------------------------------------------
// fcis_queue
// Two-entry queue of classified commands between front end and engine.
// ----------------------------------------------------------------------------
module fcis_queue import fcis_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  input  logic  pop,
  output work_t pop_data,
  output logic  empty,
  output logic  full
);

  work_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign empty    = (fill == 2'd0);
  assign full     = (fill == 2'd2);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/fcis_engine.sv =====
// ----------------------------------------------------------------------------
// fcis_engine
// Packed id store with count; scans the store one entry a cycle and commits.
// ----------------------------------------------------------------------------
module fcis_engine import fcis_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  work_t    q_data,
  output logic     pop,
  output logic     result_valid,
  output set_out_t result
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  back_state_t     state;
  back_state_t     state_next;

  logic [ID_W-1:0] mem [CAPACITY];
  logic [ID_W-1:0] rdata;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  logic [ID_W-1:0] wdata;
  logic            mem_we;

  op_t             op;
  logic [ID_W-1:0] id_value;
  logic [CW-1:0]   held_count;
  logic [CW-1:0]   held_count_next;
  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   idx;
  logic            issue;
  logic            rd_vld;
  logic [AW-1:0]   rd_idx;
  logic            hit;
  logic [AW-1:0]   pos;
  logic            is_full;

  logic            res_load;
  set_out_t        res_next;

  assign cnt_m1  = held_count - CW'(1);
  assign issue   = (state == BK_SCAN) && (idx < held_count);
  assign is_full = (held_count == CW'(CAPACITY));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty && q_data.op != OP_RESERVED) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (!issue && !rd_vld) begin
          state_next = BK_DECIDE;
        end
      end
      BK_DECIDE: begin
        if (op == OP_DELETE && hit) begin
          state_next = BK_MOVE;
        end else begin
          state_next = BK_IDLE;
        end
      end
      BK_MOVE:   state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop             = 1'b0;
    mem_we          = 1'b0;
    waddr           = pos;
    wdata           = rdata;
    raddr           = cnt_m1[AW-1:0];
    held_count_next = held_count;
    res_load        = 1'b0;
    res_next.status = STATUS_ERR;
    res_next.found  = hit;
    case (state)
      BK_IDLE: begin
        pop = !q_empty;
        if (!q_empty && q_data.op == OP_RESERVED) begin
          res_load       = 1'b1;
          res_next.found = 1'b0;
        end
      end
      BK_SCAN: begin
        raddr = idx[AW-1:0];
      end
      BK_DECIDE: begin
        case (op)
          OP_ADD: begin
            res_load = 1'b1;
            if (!is_full && !hit) begin
              mem_we          = 1'b1;
              waddr           = held_count[AW-1:0];
              wdata           = id_value;
              held_count_next = held_count + CW'(1);
              res_next.status = STATUS_OK;
            end
          end
          OP_DELETE: begin
            res_load = !hit;
          end
          OP_QUERY: begin
            res_load        = 1'b1;
            res_next.status = STATUS_OK;
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
      end
      BK_MOVE: begin
        mem_we          = 1'b1;
        held_count_next = cnt_m1;
        res_load        = 1'b1;
        res_next.status = STATUS_OK;
      end
      default: begin
      end
    endcase
    res_next.count = COUNT_W'(held_count_next);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && !q_empty) begin
      op       <= q_data.op;
      id_value <= q_data.id_value;
      idx      <= '0;
      hit      <= 1'b0;
    end else if (state == BK_SCAN) begin
      if (issue) begin
        idx <= idx + CW'(1);
      end
      if (rd_vld && rdata == id_value) begin
        hit <= 1'b1;
        pos <= rd_idx;
      end
    end
    rd_idx <= idx[AW-1:0];
    if (res_load) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      held_count   <= '0;
      rd_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      held_count   <= held_count_next;
      rd_vld       <= issue;
      result_valid <= res_load;
    end
  end

endmodule

// ===== rtl/fixed_capacity_id_set_top.sv =====
// ----------------------------------------------------------------------------
// fixed_capacity_id_set_top
// Unordered set of up to CAPACITY distinct 32-bit ids: add, delete, query.
// ----------------------------------------------------------------------------
// Commands: a transfer on item happens at a clock edge with start high and
// busy low. item.cmd is 0 add, 1 delete, 2 query; 3 is answered as a failed
// query. Every command gives exactly one result, shown on result for one
// cycle with result_valid high; the receiver cannot stall it.
// Config: cfg_data is the reserved id, written when cfg_valid and cfg_ready
// are high (cfg_ready is always high). Write it only while the block is idle.
// Timing: a two-entry queue decouples command intake from the engine. The
// engine reads the store one entry a cycle through its single read port, so
// a command occupies it for a scan over the held entries and a decide step,
// plus a move step for a delete that moves the last entry into the freed
// slot; a reserved id is answered from the idle state without a scan. The
// engine takes the next command only once it has given the last result.
// busy is high while the queue is full.
// Reset: the set is empty and the reserved id is all ones; store contents
// are not cleared, entries are only used below the count.
// ----------------------------------------------------------------------------
module fixed_capacity_id_set_top import fcis_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  set_in_t         item,
  output logic            result_valid,
  output set_out_t        result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [ID_W-1:0] cfg_data
);

  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  work_t push_data;
  work_t q_data;

  fcis_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_data (push_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fcis_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  fcis_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== tb/sv/fixed_capacity_id_set_top_tb.sv =====
// ----------------------------------------------------------------------------
// fixed_capacity_id_set_top_tb
// Self-checking bench for the id set: adds, deletes and queries are checked
// against a local shadow of the packed store. A short table covers reset,
// empty and full sets, duplicates, swap-remove and the reserved id. Random
// phases with biased ids follow under several reserved-id settings and sender
// idle rates.
// ----------------------------------------------------------------------------
module fixed_capacity_id_set_top_tb;
  import fcis_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam logic [ID_W-1:0] ALL_ONES = '1;
  localparam int unsigned POOL_N = 20;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  set_in_t         item;
  logic            result_valid;
  set_out_t        result;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [ID_W-1:0] cfg_data;

  fixed_capacity_id_set_top #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  typedef struct {
    set_in_t  cmd_in;
    bit       typed;
    set_out_t want;
  } dir_row_t;

  // shadow of the set
  logic [ID_W-1:0] shadow_ids [CAPACITY];
  int unsigned     shadow_count;
  logic [ID_W-1:0] shadow_reserved;
  set_out_t        pending_results [$];
  logic [ID_W-1:0] id_pool [POOL_N];

  logic [ID_W-1:0] fill_ids [15] = '{
    32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hAAAA_AAAA,
    32'h5555_5555, 32'h0000_0002, 32'h1234_5678, 32'hDEAD_0001, 32'h0F0F_0F0F,
    32'hF0F0_F0F0, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0100, 32'h4000_0000
  };

  int unsigned errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_full_rejects;
  int unsigned n_reserved_hits;
  int unsigned n_removes;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("tb: failure");
    $finish;
  end

  function automatic set_out_t apply_set_cmd(set_in_t x);
    set_out_t    r;
    int unsigned pos;
    r.status = STATUS_OK;
    r.found  = 1'b0;
    pos      = shadow_count;
    if (x.id_value == shadow_reserved) begin
      r.status = STATUS_ERR;
      n_reserved_hits++;
    end else begin
      for (int unsigned i = 0; i < shadow_count; i++) begin
        if (shadow_ids[i] == x.id_value && pos == shadow_count) pos = i;
      end
      r.found = (pos < shadow_count);
      case (cmd_t'(x.cmd))
        CMD_ADD: begin
          if (shadow_count >= CAPACITY || r.found) begin
            r.status = STATUS_ERR;
            if (shadow_count >= CAPACITY) n_full_rejects++;
          end else begin
            shadow_ids[shadow_count] = x.id_value;
            shadow_count++;
          end
        end
        CMD_DELETE: begin
          if (!r.found) begin
            r.status = STATUS_ERR;
          end else begin
            shadow_ids[pos] = shadow_ids[shadow_count-1];
            shadow_count--;
            n_removes++;
          end
        end
        CMD_QUERY: begin
        end
        default: r.status = STATUS_ERR;
      endcase
    end
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic set_in_t mk_cmd(cmd_t c, logic [ID_W-1:0] id);
    set_in_t x;
    x.cmd      = c;
    x.id_value = id;
    return x;
  endfunction

  function automatic dir_row_t mk_row(cmd_t c, logic [ID_W-1:0] id, bit typed,
                                      logic st = STATUS_OK, logic fd = 1'b0,
                                      int unsigned cnt = 0);
    dir_row_t row;
    row.cmd_in      = mk_cmd(c, id);
    row.typed       = typed;
    row.want.status = st;
    row.want.found  = fd;
    row.want.count  = cnt[COUNT_W-1:0];
    return row;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return id_pool[$urandom_range(POOL_N-1)];
    if (r < 68 && shadow_count != 0) return shadow_ids[$urandom_range(shadow_count-1)];
    if (r < 74) return shadow_reserved;
    return $urandom;
  endfunction

  function automatic cmd_t pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return CMD_ADD;
    if (r < 68) return CMD_DELETE;
    if (r < 91) return CMD_QUERY;
    return CMD_UNUSED;
  endfunction

  task automatic send_cmd(input set_in_t x, input bit typed, input set_out_t typed_want,
                          input int unsigned idle_pct);
    set_out_t    p;
    int unsigned gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < 24) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= x;
    do @(posedge clk); while (busy);
    p = apply_set_cmd(x);
    pending_results.push_back(typed ? typed_want : p);
    n_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reserved(input logic [ID_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_reserved = v;
  endtask

  task automatic run_random(input int unsigned n, input int unsigned idle_pct);
    set_out_t none;
    none = '0;
    repeat (n) send_cmd(mk_cmd(pick_cmd(), pick_id()), 1'b0, none, idle_pct);
  endtask

  always @(posedge clk) begin
    set_out_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status=%0b found=%0b count=%0d",
                 $time, result.status, result.found, result.count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (result.status !== want.status || result.found !== want.found ||
            result.count !== want.count) begin
          $display("%0t: mismatch, expected status=%0b found=%0b count=%0d, actual status=%0b found=%0b count=%0d",
                   $time, want.status, want.found, want.count,
                   result.status, result.found, result.count);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t        rows [$];
    logic [ID_W-1:0] held_pick;
    errors          = 0;
    n_sent          = 0;
    n_checked       = 0;
    n_full_rejects  = 0;
    n_reserved_hits = 0;
    n_removes       = 0;
    shadow_count    = 0;
    shadow_reserved = ALL_ONES;
    foreach (shadow_ids[i]) shadow_ids[i] = '0;
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;

    id_pool[0] = '0;
    id_pool[1] = ALL_ONES;
    id_pool[2] = 32'h8000_0000;
    id_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_N; i++) id_pool[i] = $urandom;

    rows.push_back(mk_row(CMD_QUERY,  32'h0,    1'b1, STATUS_OK,  1'b0, 0));
    rows.push_back(mk_row(CMD_DELETE, 32'h5,    1'b1, STATUS_ERR, 1'b0, 0));
    rows.push_back(mk_row(CMD_ADD,    ALL_ONES, 1'b1, STATUS_ERR, 1'b0, 0));
    rows.push_back(mk_row(CMD_ADD,    32'h0,    1'b1, STATUS_OK,  1'b0, 1));
    foreach (fill_ids[k]) rows.push_back(mk_row(CMD_ADD, fill_ids[k], 1'b0));
    // set is full here
    rows.push_back(mk_row(CMD_ADD,    32'h3,          1'b1, STATUS_ERR, 1'b0, 16));
    rows.push_back(mk_row(CMD_ADD,    32'hFFFF_FFFE,  1'b1, STATUS_ERR, 1'b1, 16));
    rows.push_back(mk_row(CMD_UNUSED, 32'h5555_5555,  1'b1, STATUS_ERR, 1'b1, 16));
    rows.push_back(mk_row(CMD_QUERY,  ALL_ONES,       1'b1, STATUS_ERR, 1'b0, 16));
    rows.push_back(mk_row(CMD_DELETE, 32'h0,          1'b0));
    rows.push_back(mk_row(CMD_QUERY,  32'h4000_0000,  1'b0));
    rows.push_back(mk_row(CMD_DELETE, 32'h0,          1'b1, STATUS_ERR, 1'b0, 15));
    rows.push_back(mk_row(CMD_DELETE, 32'h4000_0000,  1'b0));
    rows.push_back(mk_row(CMD_ADD,    32'h0,          1'b0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[r]) send_cmd(rows[r].cmd_in, rows[r].typed, rows[r].want, 34);

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      held_pick = shadow_count != 0 ? shadow_ids[$urandom_range(shadow_count-1)] : $urandom;
      case (ph)
        0, 4:    write_reserved('0);
        1:       write_reserved(ALL_ONES);
        2, 5:    write_reserved(held_pick);
        default: write_reserved($urandom);
      endcase
      case (ph % 3)
        0:       run_random(100, 34);
        1:       run_random(100, 73);
        default: run_random(100, 0);
      endcase
    end

    drain_results();
    repeat (30) @(posedge clk);
    $display("summary: %0d commands, %0d results checked, %0d removes, %0d full-set rejects",
             n_sent, n_checked, n_removes, n_full_rejects);
    $display("summary: %0d reserved-id hits over 7 reserved-id settings", n_reserved_hits);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
